>>> src/mjt_pkg.sv
package mjt_pkg;

	// fixed field widths
	localparam int POS_W     = 32;
	localparam int VEL_W     = 48;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_AXES  = 3;

	// velocity scaling and quotient width of the velocity divider
	localparam int VEL_FRAC_SHIFT = 16;
	localparam int VQUO_W         = 54;

	// quintic position and velocity coefficients
	localparam int P_C3 = 10;
	localparam int P_C4 = 15;
	localparam int P_C5 = 6;
	localparam int Q_C2 = 30;
	localparam int Q_C3 = 60;
	localparam int Q_C4 = 30;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X,
		REG_START_Y,
		REG_START_Z,
		REG_END_X,
		REG_END_Y,
		REG_END_Z,
		REG_DURATION
	} cfg_reg_t;

	// one result transaction
	typedef struct packed {
		logic [NUM_AXES-1:0][POS_W-1:0] pos;
		logic [NUM_AXES-1:0][VEL_W-1:0] vel;
		logic                           done;
	} res_t;

endpackage

>>> src/mjt_div_pipe.sv
module mjt_div_pipe #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [QW:0]   quo,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [0:QW];
	logic [NW-1:0] num_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          vld_s  [0:QW];

	logic [DW:0]   twice_rem;
	logic          rnd_up;
	logic [QW:0]   quo_q;
	logic [SW-1:0] side_q;
	logic          vld_q;

	// head of the divider: partial remainder starts from the bits above the quotient
	always_comb begin
		rem_s[0]  = DW'(num >> QW);
		num_s[0]  = num;
		quo_s[0]  = '0;
		side_s[0] = side_in;
		vld_s[0]  = in_vld;
	end

	// one restoring step per stage, quotient msb first
	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int B = QW - 1 - i;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[i], num_s[i][B]};
			diff  = trial - {1'b0, den};
			ge    = (trial >= {1'b0, den});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_s[i+1]  <= num_s[i];
				quo_s[i+1]  <= quo_s[i] | (QW'(ge) << B);
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// round to nearest, ties upward
	always_comb begin
		twice_rem = {rem_s[QW], 1'b0};
		rnd_up    = (twice_rem >= {1'b0, den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q  <= {1'b0, quo_s[QW]} + (QW+1)'(rnd_up);
			side_q <= side_s[QW];
		end
	end

	assign out_vld  = vld_q;
	assign quo      = quo_q;
	assign side_out = side_q;

endmodule

>>> src/mjt_poly.sv
module mjt_poly #(
	parameter int FB = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [FB:0] s,
	input  logic        done_in,
	output logic        out_vld,
	output logic [FB:0] p,
	output logic [FB+5:0] q,
	output logic        done_out
);
	import mjt_pkg::*;

	localparam int SUM_W = FB + 8;

	// fixed point product with rounding, ties upward
	function automatic logic [FB:0] rmul(input logic [FB:0] a, input logic [FB:0] b);
		logic [2*FB+1:0] prod;
		prod = (2*FB+2)'(a) * (2*FB+2)'(b) + ((2*FB+2)'(1) << (FB - 1));
		return prod[2*FB:FB];
	endfunction

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic        done_s1, done_s2, done_s3, done_s4, done_s5;
	logic [FB:0] s_s1, s_s2, s_s3;
	logic [FB:0] p2_s1, p2_s2, p2_s3, p2_s4;
	logic [FB:0] p3_s2, p3_s3, p3_s4;
	logic [FB:0] p4_s3, p4_s4;
	logic [FB:0] p5_s4;
	logic [FB:0] p_s5;
	logic [FB+5:0] q_s5;

	logic signed [SUM_W-1:0] e2, e3, e4, e5;
	logic signed [SUM_W-1:0] p_raw, q_raw;
	logic signed [SUM_W-1:0] one_w;
	logic [FB:0]             p_nxt;
	logic [FB+5:0]           q_nxt;

	// valid and done travel with the powers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// one power per stage, then the clamped polynomial results in a final stage
	always_ff @(posedge clk) begin
		if (en) begin
			done_s1 <= done_in;
			s_s1    <= s;
			p2_s1   <= rmul(s, s);

			done_s2 <= done_s1;
			s_s2    <= s_s1;
			p2_s2   <= p2_s1;
			p3_s2   <= rmul(p2_s1, s_s1);

			done_s3 <= done_s2;
			s_s3    <= s_s2;
			p2_s3   <= p2_s2;
			p3_s3   <= p3_s2;
			p4_s3   <= rmul(p3_s2, s_s2);

			done_s4 <= done_s3;
			p2_s4   <= p2_s3;
			p3_s4   <= p3_s3;
			p4_s4   <= p4_s3;
			p5_s4   <= rmul(p4_s3, s_s3);

			done_s5 <= done_s4;
			p_s5    <= p_nxt;
			q_s5    <= q_nxt;
		end
	end

	// position and velocity polynomials with clamping
	always_comb begin
		e2    = SUM_W'(p2_s4);
		e3    = SUM_W'(p3_s4);
		e4    = SUM_W'(p4_s4);
		e5    = SUM_W'(p5_s4);
		one_w = SUM_W'(1) << FB;
		p_raw = e3 * SUM_W'(P_C3) - e4 * SUM_W'(P_C4) + e5 * SUM_W'(P_C5);
		q_raw = e2 * SUM_W'(Q_C2) - e3 * SUM_W'(Q_C3) + e4 * SUM_W'(Q_C4);
		if (p_raw < 0) begin
			p_nxt = '0;
		end else if (p_raw > one_w) begin
			p_nxt = one_w[FB:0];
		end else begin
			p_nxt = p_raw[FB:0];
		end
		if (q_raw < 0) begin
			q_nxt = '0;
		end else begin
			q_nxt = q_raw[FB+5:0];
		end
	end

	assign out_vld  = vld_s5;
	assign p        = p_s5;
	assign q        = q_s5;
	assign done_out = done_s5;

endmodule

>>> src/mjt_axes.sv
module mjt_axes #(
	parameter int FB = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [FB:0]          p,
	input  logic [FB+5:0]        q,
	input  logic                 done_in,
	input  logic [mjt_pkg::POS_W-1:0] start_pos [mjt_pkg::NUM_AXES],
	input  logic [mjt_pkg::POS_W-1:0] end_pos   [mjt_pkg::NUM_AXES],
	input  logic [31:0]          dur,
	output logic                 out_vld,
	output mjt_pkg::res_t        res
);
	import mjt_pkg::*;

	localparam int PPW = FB + 33;
	localparam int VNW = FB + 38;
	localparam int NW  = VNW + VEL_FRAC_SHIFT;
	localparam int DW  = 32 + FB;
	localparam int SW  = PPW + 2;

	localparam logic signed [35:0] POS_MAX = 36'sh07FFFFFFF;
	localparam logic signed [35:0] POS_MIN = 36'shF80000000;
	localparam logic [VQUO_W:0]    VMAX    = ((VQUO_W+1)'(1) << (VEL_W - 1)) - (VQUO_W+1)'(1);
	localparam logic [VQUO_W:0]    VLIM    = (VQUO_W+1)'(1) << (VEL_W - 1);

	logic            vld_s1, vld_s2;
	logic            done_s2;
	logic [FB:0]     p_s1;
	logic [FB+5:0]   q_s1;
	logic            done_s1;
	logic [31:0]     mag_s1   [NUM_AXES];
	logic            neg_s1   [NUM_AXES];
	logic            neg_s2   [NUM_AXES];
	logic [PPW-1:0]  pprod_s2 [NUM_AXES];
	logic [VNW-1:0]  vnum_s2  [NUM_AXES];

	logic [VQUO_W:0] quo_d    [NUM_AXES];
	logic [SW-1:0]   side_d   [NUM_AXES];
	logic            vld_lane [NUM_AXES];
	logic [POS_W-1:0] pos_nxt [NUM_AXES];
	logic [VEL_W-1:0] vel_nxt [NUM_AXES];
	logic            vld_d;
	logic            vld_s3;
	res_t            res_s3;
	logic [DW-1:0]   den;

	assign den = {dur, FB'(0)};

	// shared stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p;
			q_s1    <= q;
			done_s1 <= done_in;
			done_s2 <= done_s1;
		end
	end

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
		logic signed [32:0] delta;
		logic [PPW:0]       psum;
		logic [33:0]        pm;
		logic signed [35:0] base;
		logic signed [35:0] pos_w;
		logic [VQUO_W:0]    vm;
		logic               neg_o;

		// travel distance magnitude and sign
		assign delta = {end_pos[k][31], end_pos[k]} - {start_pos[k][31], start_pos[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[k]   <= delta[32];
				mag_s1[k]   <= delta[32] ? 32'(-delta) : delta[31:0];
				neg_s2[k]   <= neg_s1[k];
				pprod_s2[k] <= PPW'(mag_s1[k]) * PPW'(p_s1);
				vnum_s2[k]  <= VNW'(mag_s1[k]) * VNW'(q_s1);
			end
		end

		// velocity: distance times q over duration
		mjt_div_pipe #(
			.NW(NW),
			.DW(DW),
			.QW(VQUO_W),
			.SW(SW)
		) u_vdiv (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld_s2),
			.num      ({vnum_s2[k], VEL_FRAC_SHIFT'(0)}),
			.den      (den),
			.side_in  ({done_s2, neg_s2[k], pprod_s2[k]}),
			.out_vld  (vld_lane[k]),
			.quo      (quo_d[k]),
			.side_out (side_d[k])
		);

		// position rounding, offset and saturation; velocity saturation
		always_comb begin
			neg_o = side_d[k][PPW];
			psum  = {1'b0, side_d[k][PPW-1:0]} + ((PPW+1)'(1) << (FB - 1));
			pm    = psum[PPW:FB];
			base  = {{4{start_pos[k][31]}}, start_pos[k]};
			pos_w = neg_o ? base - {2'b00, pm} : base + {2'b00, pm};
			if (pos_w > POS_MAX) begin
				pos_nxt[k] = POS_MAX[31:0];
			end else if (pos_w < POS_MIN) begin
				pos_nxt[k] = POS_MIN[31:0];
			end else begin
				pos_nxt[k] = pos_w[31:0];
			end
			if (neg_o) begin
				vm         = (quo_d[k] > VLIM) ? VLIM : quo_d[k];
				vel_nxt[k] = VEL_W'(-vm);
			end else begin
				vm         = (quo_d[k] > VMAX) ? VMAX : quo_d[k];
				vel_nxt[k] = vm[VEL_W-1:0];
			end
		end
	end

	// lane dividers run in lockstep, so their valid bits agree
	always_comb begin
		vld_d = 1'b1;
		for (int k = 0; k < NUM_AXES; k++) begin
			vld_d = vld_d && vld_lane[k];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				res_s3.pos[k] <= pos_nxt[k];
				res_s3.vel[k] <= vel_nxt[k];
			end
			res_s3.done <= side_d[0][PPW+1];
		end
	end

	assign out_vld = vld_s3;
	assign res     = res_s3;

endmodule

>>> src/mjt_skid.sv
module mjt_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  mjt_pkg::res_t in_res,
	output logic          en,
	output logic          out_valid,
	input  logic          out_stall,
	output mjt_pkg::res_t out_res
);
	import mjt_pkg::*;

	logic full_q;
	logic vld_q;
	logic take;
	res_t res_q;
	res_t skid_q;

	assign take = vld_q && !out_stall;
	assign en   = !full_q;

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (full_q) begin
				if (take) begin
					full_q <= 1'b0;
				end
			end else if (in_vld) begin
				if (vld_q && !take) begin
					full_q <= 1'b1;
				end else begin
					vld_q <= 1'b1;
				end
			end else if (take) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (full_q) begin
			if (take) begin
				res_q <= skid_q;
			end
		end else if (in_vld) begin
			if (vld_q && !take) begin
				skid_q <= in_res;
			end else begin
				res_q <= in_res;
			end
		end
	end

	assign out_valid = vld_q;
	assign out_res   = res_q;

`ifndef ASSERT_OFF
	// skid entry only holds data behind a pending output
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> vld_q)
		else $error("skid full without output valid");

	// skid fills only while the output is stalled
	a_fill_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> $past(vld_q && out_stall))
		else $error("skid filled without output stall");

	// a full skid keeps the output valid next cycle
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> vld_q)
		else $error("output dropped while skid full");
`endif

endmodule

>>> src/minimum_jerk_trajectory_xyz.sv
// channel   | signals                                       | direction
// ----------+-----------------------------------------------+----------
// config    | cfg_we, cfg_idx, cfg_wdata                    | in
// input     | in_valid, in_stall, elapsed_ticks             | in (in_stall is out)
// output    | out_valid, out_stall, pos_*, vel_*, done_res  | out (out_stall is in)
//
// one transaction per cycle sustained while the skid entry is empty
// the pipeline holds the bit-per-stage phase divider and the 54-stage velocity divider
// reset clears valid bits; config resets to zero positions and duration one
// an output stall freezes the whole pipeline while the skid entry holds a transaction
module minimum_jerk_trajectory_xyz #(
	parameter int PHASE_FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mjt_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mjt_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       elapsed_ticks,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mjt_pkg::POS_W-1:0]  pos_x,
	output logic signed [mjt_pkg::POS_W-1:0]  pos_y,
	output logic signed [mjt_pkg::POS_W-1:0]  pos_z,
	output logic signed [mjt_pkg::VEL_W-1:0]  vel_x,
	output logic signed [mjt_pkg::VEL_W-1:0]  vel_y,
	output logic signed [mjt_pkg::VEL_W-1:0]  vel_z,
	output logic                              done_res
);
	import mjt_pkg::*;

	localparam int FB = PHASE_FRAC_BITS;

	logic [POS_W-1:0] start_q [NUM_AXES];
	logic [POS_W-1:0] end_q   [NUM_AXES];
	logic [31:0]      dur_q;
	logic [31:0]      tn;

	logic             en;
	logic             vld_s1, vld_s2;
	logic [31:0]      t_s1;
	logic [31:0]      tc_s2;
	logic             done_s2;

	logic             ph_vld;
	logic [FB+1:0]    ph_quo;
	logic             ph_done;
	logic             pl_vld;
	logic [FB:0]      pl_p;
	logic [FB+5:0]    pl_q;
	logic             pl_done;
	logic             ax_vld;
	res_t             ax_res;
	res_t             out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				start_q[k] <= '0;
				end_q[k]   <= '0;
			end
			dur_q <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_START_X:  start_q[0] <= cfg_wdata;
				REG_START_Y:  start_q[1] <= cfg_wdata;
				REG_START_Z:  start_q[2] <= cfg_wdata;
				REG_END_X:    end_q[0]   <= cfg_wdata;
				REG_END_Y:    end_q[1]   <= cfg_wdata;
				REG_END_Z:    end_q[2]   <= cfg_wdata;
				REG_DURATION: dur_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a zero duration behaves as a finished move
	assign tn = (dur_q == 32'd0) ? 32'd1 : dur_q;

	assign in_stall = !en;

	// input register and time clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid && !in_stall;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= elapsed_ticks;
			done_s2 <= (t_s1 >= dur_q);
			tc_s2   <= (t_s1 >= dur_q) ? tn : t_s1;
		end
	end

	// phase s = t / T
	mjt_div_pipe #(
		.NW(32 + FB),
		.DW(32),
		.QW(FB + 1),
		.SW(1)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.num      ({tc_s2, FB'(0)}),
		.den      (tn),
		.side_in  (done_s2),
		.out_vld  (ph_vld),
		.quo      (ph_quo),
		.side_out (ph_done)
	);

	mjt_poly #(
		.FB(FB)
	) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (ph_vld),
		.s        (ph_quo[FB:0]),
		.done_in  (ph_done),
		.out_vld  (pl_vld),
		.p        (pl_p),
		.q        (pl_q),
		.done_out (pl_done)
	);

	mjt_axes #(
		.FB(FB)
	) u_axes (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (pl_vld),
		.p         (pl_p),
		.q         (pl_q),
		.done_in   (pl_done),
		.start_pos (start_q),
		.end_pos   (end_q),
		.dur       (tn),
		.out_vld   (ax_vld),
		.res       (ax_res)
	);

	mjt_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (ax_vld),
		.in_res    (ax_res),
		.en        (en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign pos_x    = out_res.pos[0];
	assign pos_y    = out_res.pos[1];
	assign pos_z    = out_res.pos[2];
	assign vel_x    = out_res.vel[0];
	assign vel_y    = out_res.vel[1];
	assign vel_z    = out_res.vel[2];
	assign done_res = out_res.done;

`ifndef ASSERT_OFF
	// a finished move has come to rest
	a_done_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> vel_x == '0 && vel_y == '0 && vel_z == '0)
		else $error("nonzero velocity on finished move");

	// a finished move sits on its target
	a_done_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |->
			pos_x == end_q[0] && pos_y == end_q[1] && pos_z == end_q[2])
		else $error("finished move off target");

	// input is held off exactly while the pipeline is frozen
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending output");
`endif

endmodule

>>> tb/mjt_checker.sv
module mjt_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mjt_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mjt_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [31:0]                       elapsed_ticks,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [mjt_pkg::POS_W-1:0]  pos_x,
	input  logic signed [mjt_pkg::POS_W-1:0]  pos_y,
	input  logic signed [mjt_pkg::POS_W-1:0]  pos_z,
	input  logic signed [mjt_pkg::VEL_W-1:0]  vel_x,
	input  logic signed [mjt_pkg::VEL_W-1:0]  vel_y,
	input  logic signed [mjt_pkg::VEL_W-1:0]  vel_z,
	input  logic                              done_res,
	output int                                errors,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mjt_pkg::*;

	localparam int FRAC = 24;
	localparam logic [63:0] ONE = 64'd1 << FRAC;
	localparam logic [63:0] VEL_MAX = (64'd1 << 47) - 64'd1;

	// shadow copy of the configuration registers
	logic [31:0] start_pos [NUM_AXES];
	logic [31:0] end_pos [NUM_AXES];
	logic [31:0] duration;

	res_t expected_points [$];

	// round to nearest, ties upward, saturating to 64 bits
	function automatic logic [63:0] div_round(logic [127:0] num, logic [127:0] den);
		logic [127:0] quo;
		logic [127:0] rem;
		quo = num / den;
		rem = num % den;
		if ((rem << 1) >= den)
			quo = quo + 128'd1;
		if (quo[127:64] != '0)
			return '1;
		return quo[63:0];
	endfunction

	function automatic logic [63:0] phase_mul(logic [63:0] a, logic [63:0] b);
		return div_round(128'(a) * 128'(b), 128'(ONE));
	endfunction

	// expected trajectory point for one elapsed time
	function automatic res_t trajectory_point(logic [31:0] t);
		res_t r;
		logic [63:0] s, s2, s3, s4, s5, pm, vm;
		longint p, q, a, d, pos;
		logic [63:0] mag;
		logic [31:0] tc;
		logic neg;
		r.done = (t >= duration);
		tc = r.done ? duration : t;
		s = (duration == 0) ? ONE : div_round(128'(tc) << FRAC, 128'(duration));
		s2 = phase_mul(s, s);
		s3 = phase_mul(s2, s);
		s4 = phase_mul(s3, s);
		s5 = phase_mul(s4, s);
		p = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
		if (p < 0) p = 0;
		if (p > longint'(ONE)) p = longint'(ONE);
		q = 30 * longint'(s2) - 60 * longint'(s3) + 30 * longint'(s4);
		if (q < 0) q = 0;
		for (int k = 0; k < NUM_AXES; k++) begin
			a = longint'(signed'(start_pos[k]));
			d = longint'(signed'(end_pos[k])) - a;
			neg = d < 0;
			mag = neg ? 64'(-d) : 64'(d);
			pm = div_round(128'(mag) * 128'(p), 128'(ONE));
			pos = neg ? a - longint'(pm) : a + longint'(pm);
			vm = div_round((128'(mag) * 128'(q)) << 16,
				128'((duration == 0) ? 32'd1 : duration) << FRAC);
			if (pos > 64'sd2147483647) pos = 64'sd2147483647;
			if (pos < -64'sd2147483648) pos = -64'sd2147483648;
			r.pos[k] = pos[31:0];
			if (neg) begin
				if (vm > VEL_MAX + 1) vm = VEL_MAX + 1;
				r.vel[k] = 48'(-longint'(vm));
			end else begin
				if (vm > VEL_MAX) vm = VEL_MAX;
				r.vel[k] = vm[47:0];
			end
		end
		return r;
	endfunction

	// track config, predict accepted times, compare delivered points
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				start_pos[k] = '0;
				end_pos[k] = '0;
			end
			duration = 32'd1;
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_START_X: start_pos[0] = cfg_wdata;
					REG_START_Y: start_pos[1] = cfg_wdata;
					REG_START_Z: start_pos[2] = cfg_wdata;
					REG_END_X: end_pos[0] = cfg_wdata;
					REG_END_Y: end_pos[1] = cfg_wdata;
					REG_END_Z: end_pos[2] = cfg_wdata;
					REG_DURATION: duration = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_points.push_back(trajectory_point(elapsed_ticks));
			if (out_valid && !out_stall) begin
				got.pos[0] = pos_x;
				got.pos[1] = pos_y;
				got.pos[2] = pos_z;
				got.vel[0] = vel_x;
				got.vel[1] = vel_y;
				got.vel[2] = vel_z;
				got.done = done_res;
				if (expected_points.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction pos %h vel %h done %b",
						$realtime, got.pos, got.vel, got.done);
				end else begin
					want = expected_points.pop_front();
					for (int k = 0; k < NUM_AXES; k++) begin
						if (got.pos[k] !== want.pos[k]) begin
							errors++;
							$display("%0t: pos axis %0d expected %h actual %h",
								$realtime, k, want.pos[k], got.pos[k]);
						end
						if (got.vel[k] !== want.vel[k]) begin
							errors++;
							$display("%0t: vel axis %0d expected %h actual %h",
								$realtime, k, want.vel[k], got.vel[k]);
						end
					end
					if (got.done !== want.done) begin
						errors++;
						$display("%0t: done expected %b actual %b",
							$realtime, want.done, got.done);
					end
				end
			end
		end
		pending = expected_points.size();
	end

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mjt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 120;
	localparam int NUM_REGS = 7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [31:0] elapsed_ticks;
	logic out_valid;
	logic out_stall;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
	logic done_res;
	int errors;
	int pending;

	bit quiet;
	bit hold_req;
	int cycle_cnt;
	int items_sent;
	int settings_used;
	logic [31:0] cur_duration;

	minimum_jerk_trajectory_xyz i_dut (.*);

	mjt_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// global timeout
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 12);
			end
		end
	end

	task automatic send_time(logic [31:0] t);
		while (!quiet && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_ticks <= t;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all registers, plus one write to an unused index
	task automatic load_config(logic [31:0] v [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IDX_W'(i);
			cfg_wdata <= v[i];
			@(posedge clk);
		end
		cfg_idx <= '1;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_duration = v[REG_DURATION];
		settings_used++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(signed'($urandom_range(65536 * 8)) - 65536 * 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_duration();
		case ($urandom_range(7))
			0: return 32'd1;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(2000, 1);
		endcase
	endfunction

	// mostly times within the move, some past it, some arbitrary
	function automatic logic [31:0] rand_time(logic [31:0] dur);
		logic [63:0] span;
		span = 64'(dur) + 64'(dur) / 8 + 2;
		if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: return dur;
			default: return $urandom_range(32'(span), 0);
		endcase
	endfunction

	logic [31:0] cfg_vals [NUM_REGS];

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 0;
		elapsed_ticks = '0;
		quiet = 0;
		hold_req = 0;
		cycle_cnt = 0;
		items_sent = 0;
		settings_used = 0;
		cur_duration = 32'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset configuration: zero move, duration one
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'hFFFF_FFFF);
		wait_drained();

		// full-scale move up on x, mixed moves on y and z, mid duration
		cfg_vals = '{32'h8000_0000, 32'h8000_0000, 32'd0,
			32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd1000};
		load_config(cfg_vals);
		foreach (cfg_vals[i]) ;
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'd250);
		send_time(32'd500);
		send_time(32'd999);
		send_time(32'd1000);
		send_time(32'd1001);
		send_time(32'hFFFF_FFFF);
		wait_drained();

		// full-scale move down on x over the longest duration, phase rounds up near the end
		cfg_vals = '{32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
			32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF};
		load_config(cfg_vals);
		send_time(32'd0);
		send_time(32'h7FFF_FFFF);
		send_time(32'hFFFF_FFF0);
		send_time(32'hFFFF_FFFD);
		send_time(32'hFFFF_FFFE);
		send_time(32'hFFFF_FFFF);
		wait_drained();

		// duration of two with full-scale distance saturates velocity
		cfg_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd2};
		load_config(cfg_vals);
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'd2);
		send_time(32'd3);
		wait_drained();

		// random settings and times
		for (int ph = 0; ph < 8; ph++) begin
			foreach (cfg_vals[i])
				cfg_vals[i] = (i == REG_DURATION) ? rand_duration() : rand_coord();
			load_config(cfg_vals);
			quiet = (ph == 3);
			if (ph == 2)
				hold_req = 1;
			for (int n = 0; n < 240; n++)
				send_time(rand_time(cur_duration));
			quiet = 0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d time samples over %0d register settings", items_sent,
			settings_used);
		$display("including extreme positions, durations and times past the end");
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
src/mjt_pkg.sv
src/mjt_div_pipe.sv
src/mjt_poly.sv
src/mjt_axes.sv
src/mjt_skid.sv
src/minimum_jerk_trajectory_xyz.sv
tb/mjt_checker.sv
tb/testbench.sv
